@@ hdl/field_list_spec_parser_macros.svh @@
// ----------------------------------------------------------------------------
// field_list_spec_parser_macros.svh
// assertion macros used by the checker of the field list parser
// ----------------------------------------------------------------------------
`ifndef FIELD_LIST_SPEC_PARSER_MACROS_SVH
`define FIELD_LIST_SPEC_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FLSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("field list parser check failed");

// next-cycle implication, sampled on clk, off during reset
`define FLSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("field list parser check failed");

`endif

@@ hdl/flsp_pkg.sv @@
// ----------------------------------------------------------------------------
// flsp_pkg
// types, constants and status codes of the field list parser
// ----------------------------------------------------------------------------
`default_nettype none

package flsp_pkg;

  localparam int MAP_BITS   = 64;
  localparam int IDX_W      = $clog2(MAP_BITS);
  localparam int VAL_W      = 31;
  localparam int MAP_PORT_W = 64;
  localparam int OUT_RAW_W  = 3 + MAP_PORT_W + 1 + 1 + VAL_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_NO_END   = 3'd3;
  localparam logic [2:0] ST_DECREASE = 3'd4;
  localparam logic [2:0] ST_MISSING  = 3'd5;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // one token as collected by a track
  typedef struct packed {
    logic             dash;
    logic             lne;
    logic             lbad;
    logic             rne;
    logic             rbad;
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] right;
  } token_t;

  // finished token handed to the accumulator of a track
  typedef struct packed {
    logic   valid;
    logic   empty_after;  // a trailing empty token follows (list ends on a comma)
    token_t tok;
  } tok_evt_t;

  typedef struct packed {
    logic valid;
    logic comma_seen;
    logic ws_done;
  } end_info_t;

  typedef struct packed {
    logic [2:0]          err;
    logic [MAP_BITS-1:0] map;
    logic                beyond;
    logic                open_v;
    logic [VAL_W-1:0]    open_s;
  } track_sum_t;

endpackage

`default_nettype wire

@@ hdl/flsp_scanner.sv @@
// ----------------------------------------------------------------------------
// flsp_scanner
// input register and the two character tracks; emits finished tokens
// ----------------------------------------------------------------------------
`default_nettype none

module flsp_scanner (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire logic [7:0]         in_char,
  input  wire logic               in_last,
  input  wire logic               in_empty,
  output flsp_pkg::tok_evt_t      evt_ws,
  output flsp_pkg::tok_evt_t      evt_cm,
  output flsp_pkg::end_info_t     end_info
);
  import flsp_pkg::*;

  function automatic token_t mark_bad(token_t t);
    token_t r;
    r = t;
    if (t.dash) begin
      r.rne  = 1'b1;
      r.rbad = 1'b1;
    end else begin
      r.lne  = 1'b1;
      r.lbad = 1'b1;
    end
    return r;
  endfunction

  function automatic token_t feed_char(token_t t, logic [7:0] c);
    token_t           r;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] nv;
    logic [VAL_W+3:0] n;
    logic             digit;
    r = t;
    if (c == CH_DASH && !t.dash) begin
      r.dash = 1'b1;
    end else begin
      v = t.dash ? t.right : t.left;
      if (t.dash) begin
        r.rne = 1'b1;
      end else begin
        r.lne = 1'b1;
      end
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      // v * 10 + digit
      n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{VAL_W{1'b0}}, c[3:0]};
      nv = v;
      if (!digit) begin
        r = mark_bad(r);
      end else if (n > {4'b0000, VAL_MAX}) begin
        r  = mark_bad(r);
        nv = VAL_MAX;
      end else begin
        nv = n[VAL_W-1:0];
      end
      if (t.dash) begin
        r.right = nv;
      end else begin
        r.left = nv;
      end
    end
    return r;
  endfunction

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       s1_empty_r;

  logic   comma_seen_r, comma_seen_nxt;
  logic   ws_in_r, ws_in_nxt;
  logic   ws_done_r, ws_done_nxt;
  token_t ws_tok_r, ws_tok_nxt;
  logic   cm_in_r, cm_in_nxt;
  logic   cm_pend_r, cm_pend_nxt;
  token_t cm_tok_r, cm_tok_nxt;

  tok_evt_t  evt_ws_r, evt_ws_nxt;
  tok_evt_t  evt_cm_r, evt_cm_nxt;
  end_info_t end_r, end_nxt;

  logic   take, s1_end, blank, is_comma;
  logic   ws_in_fed, ws_fin;
  token_t ws_fed, cm_fed;
  logic   cm_fin;

  always_comb begin
    take     = s1_valid_r && !s1_empty_r;
    s1_end   = s1_valid_r && (s1_last_r || s1_empty_r);
    blank    = (s1_char_r == CH_SPACE) || (s1_char_r == CH_TAB);
    is_comma = (s1_char_r == CH_COMMA);

    // whitespace track
    ws_fed    = (take && !blank) ? feed_char(ws_tok_r, s1_char_r) : ws_tok_r;
    ws_in_fed = ws_in_r || (take && !blank);
    ws_fin    = (take && blank && ws_in_r) || (s1_end && ws_in_fed);

    // comma track
    cm_fed      = cm_tok_r;
    cm_in_nxt   = cm_in_r;
    cm_pend_nxt = cm_pend_r;
    cm_tok_nxt  = cm_tok_r;
    if (take && is_comma) begin
      cm_in_nxt   = 1'b0;
      cm_pend_nxt = 1'b0;
      cm_tok_nxt  = '0;
    end else if (take && blank) begin
      cm_pend_nxt = cm_pend_r || cm_in_r;
    end else if (take) begin
      // a blank between two non-blanks spoils the token part
      cm_fed      = feed_char(cm_pend_r ? mark_bad(cm_tok_r) : cm_tok_r, s1_char_r);
      cm_in_nxt   = 1'b1;
      cm_pend_nxt = 1'b0;
      cm_tok_nxt  = cm_fed;
    end
    cm_fin = (take && is_comma) || s1_end;

    comma_seen_nxt = comma_seen_r || (take && is_comma);

    ws_in_nxt   = ws_in_fed;
    ws_done_nxt = ws_done_r || ws_fin;
    ws_tok_nxt  = ws_fed;
    if (ws_fin) begin
      ws_in_nxt  = 1'b0;
      ws_tok_nxt = '0;
    end

    evt_ws_nxt.valid       = ws_fin;
    evt_ws_nxt.empty_after = 1'b0;
    evt_ws_nxt.tok         = ws_fed;
    evt_cm_nxt.valid       = cm_fin;
    evt_cm_nxt.empty_after = take && is_comma && s1_end;
    evt_cm_nxt.tok         = cm_fed;
    end_nxt.valid          = s1_end;
    end_nxt.comma_seen     = comma_seen_nxt;
    end_nxt.ws_done        = ws_done_nxt;

    // end of list: back to the idle state
    if (s1_end) begin
      comma_seen_nxt = 1'b0;
      ws_in_nxt      = 1'b0;
      ws_done_nxt    = 1'b0;
      ws_tok_nxt     = '0;
      cm_in_nxt      = 1'b0;
      cm_pend_nxt    = 1'b0;
      cm_tok_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_char_r  <= in_char;
      s1_last_r  <= in_last;
      s1_empty_r <= in_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      comma_seen_r <= 1'b0;
      ws_in_r      <= 1'b0;
      ws_done_r    <= 1'b0;
      ws_tok_r     <= '0;
      cm_in_r      <= 1'b0;
      cm_pend_r    <= 1'b0;
      cm_tok_r     <= '0;
      evt_ws_r     <= '0;
      evt_cm_r     <= '0;
      end_r        <= '0;
    end else if (adv) begin
      s1_valid_r   <= in_valid;
      comma_seen_r <= comma_seen_nxt;
      ws_in_r      <= ws_in_nxt;
      ws_done_r    <= ws_done_nxt;
      ws_tok_r     <= ws_tok_nxt;
      cm_in_r      <= cm_in_nxt;
      cm_pend_r    <= cm_pend_nxt;
      cm_tok_r     <= cm_tok_nxt;
      evt_ws_r     <= evt_ws_nxt;
      evt_cm_r     <= evt_cm_nxt;
      end_r        <= end_nxt;
    end
  end

  assign evt_ws   = evt_ws_r;
  assign evt_cm   = evt_cm_r;
  assign end_info = end_r;

endmodule

`default_nettype wire

@@ hdl/flsp_track_acc.sv @@
// ----------------------------------------------------------------------------
// flsp_track_acc
// checks one finished token and folds it into the map, open start and status
// ----------------------------------------------------------------------------
`default_nettype none

module flsp_track_acc (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               clear,
  input  wire flsp_pkg::tok_evt_t evt,
  output flsp_pkg::track_sum_t    sum
);
  import flsp_pkg::*;

  track_sum_t sum_r, sum_nxt, base;

  logic [2:0]          code;
  logic                do_range, do_open;
  logic [VAL_W-1:0]    lm1, rm1, lo, hi;
  logic                lo_big, hi_big;
  logic [IDX_W-1:0]    lo_s, hi_s;
  logic [MAP_BITS-1:0] mask;
  token_t              tok;

  always_comb begin
    tok      = evt.tok;
    lm1      = tok.left - 1'b1;
    rm1      = tok.right - 1'b1;
    code     = ST_OK;
    do_range = 1'b0;
    do_open  = 1'b0;
    lo       = '0;
    hi       = '0;
    if (!tok.dash) begin
      if (!tok.lne || tok.lbad) begin
        code = ST_INVALID;
      end else if (tok.left == '0) begin
        code = ST_ZERO;
      end else begin
        do_range = 1'b1;
        lo       = lm1;
        hi       = lm1;
      end
    end else if (!tok.lne) begin
      if (!tok.rne) begin
        code = ST_NO_END;
      end else if (tok.rbad) begin
        code = ST_INVALID;
      end else if (tok.right == '0) begin
        code = ST_ZERO;
      end else begin
        do_range = 1'b1;
        hi       = rm1;
      end
    end else if (tok.lbad) begin
      code = ST_INVALID;
    end else if (tok.left == '0) begin
      code = ST_ZERO;
    end else if (!tok.rne) begin
      do_open = 1'b1;
    end else if (tok.rbad) begin
      code = ST_INVALID;
    end else if (tok.right == '0) begin
      code = ST_ZERO;
    end else if (tok.left > tok.right) begin
      code = ST_DECREASE;
    end else begin
      do_range = 1'b1;
      lo       = lm1;
      hi       = rm1;
    end

    // clamp the range to the map, then one compare pair per bit
    lo_big = lo >= VAL_W'(MAP_BITS);
    hi_big = hi >= VAL_W'(MAP_BITS);
    lo_s   = lo[IDX_W-1:0];
    hi_s   = hi_big ? IDX_W'(MAP_BITS - 1) : hi[IDX_W-1:0];
    for (int k = 0; k < MAP_BITS; k++) begin
      mask[k] = !lo_big && (IDX_W'(k) >= lo_s) && (IDX_W'(k) <= hi_s);
    end

    // the previous list's result is taken this cycle: start from reset
    base    = clear ? '0 : sum_r;
    sum_nxt = base;
    if (evt.valid) begin
      if (base.err == ST_OK) begin
        sum_nxt.err = code;
        if (code == ST_OK && do_range) begin
          sum_nxt.map    = base.map | mask;
          sum_nxt.beyond = base.beyond | hi_big;
        end
        if (code == ST_OK && do_open && (!base.open_v || lm1 < base.open_s)) begin
          sum_nxt.open_v = 1'b1;
          sum_nxt.open_s = lm1;
        end
      end
      if (evt.empty_after && sum_nxt.err == ST_OK) begin
        sum_nxt.err = ST_INVALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (adv) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

`default_nettype wire

@@ hdl/field_list_spec_parser.sv @@
// ----------------------------------------------------------------------------
// field_list_spec_parser
// parses a cut-style field list, one character per transaction
// ----------------------------------------------------------------------------
// in_*  : one character per transaction; in_tlast marks the final character,
//         in_tuser marks an empty list (tdata ignored, tlast expected high)
// out_* : one transaction per list, at its final character: status, map of
//         closed selections, beyond-map flag and smallest open start
// a character is taken every cycle while in_tready is high; each one runs
// through the input register, the two character tracks, the per-track token
// check and the output register on the way to its list's result.
// throughput is one character per cycle while in_tready is high, set by the
// track state update feeding back on itself each cycle.
// reset (synchronous, rst_n low) empties the pipeline and returns both
// tracks to the state before a list.
// while out_tready is low, characters keep flowing in until a second result
// is ready behind the held one; then in_tready drops until out_tready rises.
// ----------------------------------------------------------------------------
`default_nettype none

module field_list_spec_parser (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [7:0]                      in_tdata,   // char_code
  input  wire logic                            in_tlast,   // is_last
  input  wire logic                            in_tuser,   // list_empty
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  // status[2:0], selected_map[66:3], beyond_map[67], open_present[68],
  // open_start_index[99:69], zero fill above
  output      logic [flsp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import flsp_pkg::*;

  logic       adv;
  tok_evt_t   evt_ws, evt_cm;
  end_info_t  end_info;
  end_info_t  s3_r;
  track_sum_t ws_sum, cm_sum, sel;
  logic       clear;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [2:0]            st;

  // only a finished result with nowhere to go holds the pipeline
  assign adv   = !(s3_r.valid && out_valid_r && !out_tready);
  assign clear = adv && s3_r.valid;

  flsp_scanner u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .in_char  (in_tdata),
    .in_last  (in_tlast),
    .in_empty (in_tuser),
    .evt_ws   (evt_ws),
    .evt_cm   (evt_cm),
    .end_info (end_info)
  );

  flsp_track_acc u_acc_ws (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .clear (clear),
    .evt   (evt_ws),
    .sum   (ws_sum)
  );

  flsp_track_acc u_acc_cm (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .clear (clear),
    .evt   (evt_cm),
    .sum   (cm_sum)
  );

  always_comb begin
    sel = s3_r.comma_seen ? cm_sum : ws_sum;
    st  = sel.err;
    if (!s3_r.comma_seen && !s3_r.ws_done) begin
      st = ST_MISSING;
    end
    out_data_nxt = '0;
    out_data_nxt[2:0] = st;
    if (st == ST_OK) begin
      out_data_nxt[3 +: MAP_PORT_W] = MAP_PORT_W'(sel.map);
      out_data_nxt[3 + MAP_PORT_W]     = sel.beyond;
      out_data_nxt[4 + MAP_PORT_W]     = sel.open_v;
      out_data_nxt[5 + MAP_PORT_W +: VAL_W] = sel.open_v ? sel.open_s : '0;
    end

    out_valid_nxt = out_valid_r && !out_tready;
    if (clear) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        s3_r <= end_info;
      end
    end
  end

  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ hdl/flsp_checker.sv @@
// ----------------------------------------------------------------------------
// flsp_checker
// port-level checks of the field list parser result channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "field_list_spec_parser_macros.svh"

module flsp_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [flsp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import flsp_pkg::*;

  logic [2:0] out_status;
  logic       out_open;

  assign out_status = out_tdata[2:0];
  assign out_open   = out_tdata[4 + MAP_PORT_W];

  // a stalled result stays put
  `FLSP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // status codes stop at missing list
  `FLSP_ASSERT_NOW(a_status_range, out_tvalid, out_status <= ST_MISSING)

  // an error result carries no selection
  `FLSP_ASSERT_NOW(a_err_clean, out_tvalid && out_status != ST_OK, out_tdata[OUT_DATA_W-1:3] == '0)

  // open start only with an open range, fill bits zero
  `FLSP_ASSERT_NOW(a_open_clean, out_tvalid && !out_open, out_tdata[OUT_DATA_W-1:68] == '0)

endmodule

bind field_list_spec_parser flsp_checker u_flsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
